// ===== sv/tsb_pkg.sv =====
// ----------------------------------------------------------------------------
// Texture slot binder package
// Shared widths, operation codes and controller interface types.
// ----------------------------------------------------------------------------
package tsb_pkg;

  localparam int OP_W          = 2;
  localparam int ID_W          = 32;
  localparam int KIND_W        = 16;
  localparam int SLOT_W        = 4;
  localparam int CFG_W         = 5;
  localparam int MAX_SLOTS_DEF = 16;

  localparam logic [CFG_W-1:0] ACTIVE_SLOTS_RESET = 5'd15;

  localparam logic [OP_W-1:0] OP_BIND       = 2'd0;
  localparam logic [OP_W-1:0] OP_UNBIND     = 2'd1;
  localparam logic [OP_W-1:0] OP_UNBIND_ALL = 2'd2;

  typedef struct packed {
    logic load;
    logic lookup;
    logic commit;
  } tsb_cmd_t;

  typedef struct packed {
    logic needs_lookup;
  } tsb_status_t;

endpackage

// ===== sv/texture_slot_binder_unit.sv =====
// ----------------------------------------------------------------------------
// Texture slot binder unit
// Fully associative ID-to-slot table with round-robin replacement.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. A bind or unbind goes
// from acceptance to its result through capture of the item, the registered
// compare of the ID against every slot, and the update of the table with the
// registered result. Unbind-all and unknown operations skip the compare. Each
// result is shown for exactly one cycle with out_valid high; the receiver
// cannot stall, so it must take the result then.
// The next item may be started in the cycle that the previous result appears.
// ----------------------------------------------------------------------------
module texture_slot_binder_unit
  import tsb_pkg::*;
#(
  parameter int MaxSlots = MAX_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [OP_W-1:0]   in_operation,
  input  logic [ID_W-1:0]   in_texture_id,
  input  logic [KIND_W-1:0] in_texture_kind,
  input  logic              cfg_we,
  input  logic [CFG_W-1:0]  cfg_wdata,
  output logic              out_valid,
  output logic [SLOT_W-1:0] out_slot,
  output logic              out_bind_needed,
  output logic              out_evicted_valid,
  output logic [ID_W-1:0]   out_evicted_id,
  output logic [KIND_W-1:0] out_bind_kind
);

  tsb_cmd_t    cmd;
  tsb_status_t status;

  tsb_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  tsb_datapath #(
    .MaxSlots (MaxSlots)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_operation      (in_operation),
    .in_texture_id     (in_texture_id),
    .in_texture_kind   (in_texture_kind),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .cmd               (cmd),
    .status            (status),
    .out_valid         (out_valid),
    .out_slot          (out_slot),
    .out_bind_needed   (out_bind_needed),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_id    (out_evicted_id),
    .out_bind_kind     (out_bind_kind)
  );

  // A result only follows a cycle in which an item was in flight.
  a_result_after_busy: assert property (
    @(posedge clk) disable iff (!rst_n) out_valid |-> $past(busy)
  ) else $error("result without an item in flight");

  // An accepted item keeps the block busy in the next cycle.
  a_busy_after_accept: assert property (
    @(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy
  ) else $error("accepted item did not raise busy");

  // Results never come back to back, since each item is captured in idle before its commit step.
  a_single_strobe: assert property (
    @(posedge clk) disable iff (!rst_n) out_valid |=> !out_valid
  ) else $error("result strobe held for more than one cycle");

  // An eviction is only reported on a bind that missed.
  a_evict_on_miss: assert property (
    @(posedge clk) disable iff (!rst_n)
      (out_valid && out_evicted_valid) |-> out_bind_needed
  ) else $error("eviction reported without a new slot assignment");

endmodule

// ===== sv/tsb_datapath.sv =====
// ----------------------------------------------------------------------------
// Texture slot binder datapath
// Slot table, parallel ID compare, round-robin pointer and result registers.
// ----------------------------------------------------------------------------
module tsb_datapath
  import tsb_pkg::*;
#(
  parameter int MaxSlots = MAX_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [OP_W-1:0]   in_operation,
  input  logic [ID_W-1:0]   in_texture_id,
  input  logic [KIND_W-1:0] in_texture_kind,
  input  logic              cfg_we,
  input  logic [CFG_W-1:0]  cfg_wdata,
  input  tsb_cmd_t          cmd,
  output tsb_status_t       status,
  output logic              out_valid,
  output logic [SLOT_W-1:0] out_slot,
  output logic              out_bind_needed,
  output logic              out_evicted_valid,
  output logic [ID_W-1:0]   out_evicted_id,
  output logic [KIND_W-1:0] out_bind_kind
);

  localparam int IDX_W = (MaxSlots > 1) ? $clog2(MaxSlots) : 1;
  localparam int CNT_W = $clog2(MaxSlots + 1);
  localparam int NW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  logic [OP_W-1:0]   op_r;
  logic [ID_W-1:0]   id_r;
  logic [KIND_W-1:0] kind_r;
  logic [ID_W-1:0]   owner_r [MaxSlots];
  logic [MaxSlots-1:0] valid_r;
  logic [IDX_W-1:0]  next_slot_r;
  logic [CFG_W-1:0]  active_r;
  logic              hit_r;
  logic [IDX_W-1:0]  hit_idx_r;

  logic [MaxSlots-1:0] match;
  logic [IDX_W-1:0]  match_idx;
  logic [NW-1:0]     act_ext;
  logic [NW-1:0]     usable;
  logic [IDX_W-1:0]  ptr;
  logic [IDX_W-1:0]  ptr_nxt;

  logic              out_valid_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic              out_bind_needed_r;
  logic              out_evicted_valid_r;
  logic [ID_W-1:0]   out_evicted_id_r;
  logic [KIND_W-1:0] out_bind_kind_r;

  assign status.needs_lookup = (in_operation == OP_BIND) || (in_operation == OP_UNBIND);

  // Valid IDs are unique in the table, so the match vector is one-hot or zero.
  always_comb begin
    match     = '0;
    match_idx = '0;
    for (int i = 0; i < MaxSlots; i++) begin
      match[i] = valid_r[i] && (owner_r[i] == id_r);
      if (match[i]) begin
        match_idx = match_idx | IDX_W'(i);
      end
    end
  end

  always_comb begin
    act_ext = NW'(active_r);
    if (act_ext == '0) begin
      usable = NW'(1);
    end else if (act_ext > NW'(MaxSlots)) begin
      usable = NW'(MaxSlots);
    end else begin
      usable = act_ext;
    end
    ptr     = (NW'(next_slot_r) < usable) ? next_slot_r : '0;
    ptr_nxt = ((NW'(ptr) + NW'(1)) >= usable) ? '0 : ptr + IDX_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= ACTIVE_SLOTS_RESET;
    end else if (cfg_we) begin
      active_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_operation;
      id_r   <= in_texture_id;
      kind_r <= in_texture_kind;
    end
    if (cmd.lookup) begin
      hit_r     <= |match;
      hit_idx_r <= match_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      next_slot_r <= '0;
    end else if (cmd.commit) begin
      unique case (op_r)
        OP_BIND: begin
          if (!hit_r) begin
            valid_r[ptr] <= 1'b1;
            next_slot_r  <= ptr_nxt;
          end
        end
        OP_UNBIND: begin
          if (hit_r) begin
            valid_r[hit_idx_r] <= 1'b0;
          end
        end
        OP_UNBIND_ALL: begin
          valid_r     <= '0;
          next_slot_r <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && (op_r == OP_BIND) && !hit_r) begin
      owner_r[ptr] <= id_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.commit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_slot_r          <= '0;
      out_bind_needed_r   <= 1'b0;
      out_evicted_valid_r <= 1'b0;
      out_evicted_id_r    <= '0;
      out_bind_kind_r     <= '0;
      if (op_r == OP_BIND) begin
        out_bind_kind_r <= kind_r;
        if (hit_r) begin
          out_slot_r <= SLOT_W'(hit_idx_r);
        end else begin
          out_slot_r        <= SLOT_W'(ptr);
          out_bind_needed_r <= 1'b1;
          if (valid_r[ptr]) begin
            out_evicted_valid_r <= 1'b1;
            out_evicted_id_r    <= owner_r[ptr];
          end
        end
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_slot          = out_slot_r;
  assign out_bind_needed   = out_bind_needed_r;
  assign out_evicted_valid = out_evicted_valid_r;
  assign out_evicted_id    = out_evicted_id_r;
  assign out_bind_kind     = out_bind_kind_r;

endmodule

// ===== sv/tsb_ctrl.sv =====
// ----------------------------------------------------------------------------
// Texture slot binder controller
// Sequences each item through capture, table compare (bind and unbind only) and table update.
// ----------------------------------------------------------------------------
module tsb_ctrl
  import tsb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  tsb_status_t status,
  output tsb_cmd_t    cmd,
  output logic        busy
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_LOOKUP = 3'b010,
    S_COMMIT = 3'b100
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd.load   = 1'b0;
    cmd.lookup = 1'b0;
    cmd.commit = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = status.needs_lookup ? S_LOOKUP : S_COMMIT;
        end
      end
      S_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_nxt  = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule
